>>> hw/rtl/crs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared widths and inter-stage payload types of the Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int HEIGHT_W = 24;
  localparam int X_W      = 32;
  localparam int Y_W      = 35;
  localparam int K_W      = 7;
  localparam int MU_W     = 16;
  localparam int SUM_W    = 48;

  typedef logic [MU_W-1:0] mu_t;

  // Doubled coefficients, step fraction and abscissa terms after the first stage.
  typedef struct packed {
    logic signed [27:0]      c0;
    logic signed [27:0]      c1;
    logic signed [24:0]      c2;
    logic [HEIGHT_W-1:0]     p1;
    mu_t                     mu;
    logic signed [X_W:0]     dx;
    logic signed [X_W-1:0]   x1;
  } front_t;

  // Partial results leaving the product pipeline.
  typedef struct packed {
    logic signed [44:0]      t0;
    logic signed [SUM_W-1:0] acc;
    logic [X_W-1:0]          x;
  } pow_t;

endpackage

>>> hw/rtl/crs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_front
// First stage: step fraction lookup, doubled coefficients and x difference.
// ----------------------------------------------------------------------------
module crs_front #(
  parameter int STEPS = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [crs_pkg::HEIGHT_W-1:0]         height_before,
  input  logic [crs_pkg::HEIGHT_W-1:0]         height_start,
  input  logic [crs_pkg::HEIGHT_W-1:0]         height_end,
  input  logic [crs_pkg::HEIGHT_W-1:0]         height_after,
  input  logic signed [crs_pkg::X_W-1:0]       start_x,
  input  logic signed [crs_pkg::X_W-1:0]       end_x,
  input  logic [crs_pkg::K_W-1:0]              step_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output crs_pkg::front_t                      out_data
);

  localparam int KDEPTH = 2 ** crs_pkg::K_W;

  crs_pkg::mu_t    mu_tab [KDEPTH];
  crs_pkg::front_t data_next;
  crs_pkg::front_t data;
  logic            valid;
  logic            en;
  logic signed [27:0] p0;
  logic signed [27:0] p1;
  logic signed [27:0] p2;
  logic signed [27:0] p3;

  // Step indexes at or beyond STEPS use the last step of the segment.
  for (genvar i = 0; i < KDEPTH; i++) begin : g_mu
    localparam int KS = (i > STEPS - 1) ? STEPS - 1 : i;
    assign mu_tab[i] = crs_pkg::MU_W'((KS * (2 ** crs_pkg::MU_W)) / STEPS);
  end

  assign p0 = $signed({4'b0, height_before});
  assign p1 = $signed({4'b0, height_start});
  assign p2 = $signed({4'b0, height_end});
  assign p3 = $signed({4'b0, height_after});

  always_comb begin
    data_next.c0 = p3 - p0 + 28'sd3 * (p1 - p2);
    data_next.c1 = 28'sd2 * p0 - 28'sd5 * p1 + 28'sd4 * p2 - p3;
    data_next.c2 = $signed({1'b0, height_end}) - $signed({1'b0, height_before});
    data_next.p1 = height_start;
    data_next.mu = mu_tab[step_index];
    data_next.dx = $signed({end_x[crs_pkg::X_W-1], end_x})
                 - $signed({start_x[crs_pkg::X_W-1], start_x});
    data_next.x1 = start_x;
  end

  assign en       = !valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

>>> hw/rtl/crs_powers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_powers
// Three product stages: powers of mu, coefficient terms and the abscissa.
// ----------------------------------------------------------------------------
module crs_powers (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  crs_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output crs_pkg::pow_t   out_data
);

  // Stage 2 registers.
  logic                         v2;
  crs_pkg::mu_t                 mu_2;
  crs_pkg::mu_t                 mu2_2;
  logic signed [27:0]           c0_2;
  logic signed [27:0]           c1_2;
  logic signed [41:0]           t2_2;
  logic [crs_pkg::HEIGHT_W-1:0] p1_2;
  logic signed [49:0]           xprod_2;
  logic signed [crs_pkg::X_W-1:0] x1_2;

  // Stage 3 registers.
  logic                         v3;
  crs_pkg::mu_t                 mu3_3;
  logic signed [27:0]           c0_3;
  logic signed [44:0]           t1_3;
  logic signed [41:0]           t2_3;
  logic [crs_pkg::HEIGHT_W-1:0] p1_3;
  logic [crs_pkg::X_W-1:0]      x_3;

  // Stage 4 registers.
  logic                         v4;
  logic signed [44:0]           t0_4;
  logic signed [crs_pkg::SUM_W-1:0] acc_4;
  logic [crs_pkg::X_W-1:0]      x_4;

  logic r2, r3, r4;
  logic signed [16:0]           mu_s1;
  logic signed [16:0]           mu2_s2;
  logic signed [16:0]           mu3_s3;
  logic [31:0]                  mu_sq;
  logic [31:0]                  mu_cube;
  logic signed [41:0]           t2_prod;
  logic signed [49:0]           x_prod;
  logic signed [44:0]           t1_prod;
  logic signed [44:0]           t0_prod;
  logic signed [crs_pkg::SUM_W-1:0] t3;

  assign r4       = !v4 || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  assign mu_s1   = $signed({1'b0, in_data.mu});
  assign mu_sq   = in_data.mu * in_data.mu;
  assign t2_prod = in_data.c2 * mu_s1;
  assign x_prod  = in_data.dx * mu_s1;

  assign mu2_s2  = $signed({1'b0, mu2_2});
  assign mu_cube = mu2_2 * mu_2;
  assign t1_prod = c1_2 * mu2_s2;

  assign mu3_s3  = $signed({1'b0, mu3_3});
  assign t0_prod = c0_3 * mu3_s3;
  // The doubled constant term 2*P1 in Q.16 is P1 shifted up by 17.
  assign t3      = $signed({7'b0, p1_3, 17'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= in_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && in_valid) begin
      mu_2    <= in_data.mu;
      mu2_2   <= mu_sq[31:16];
      c0_2    <= in_data.c0;
      c1_2    <= in_data.c1;
      t2_2    <= t2_prod;
      p1_2    <= in_data.p1;
      xprod_2 <= x_prod;
      x1_2    <= in_data.x1;
    end
    if (r3 && v2) begin
      mu3_3 <= mu_cube[31:16];
      c0_3  <= c0_2;
      t1_3  <= t1_prod;
      t2_3  <= t2_2;
      p1_3  <= p1_2;
      // Floor of the scaled difference, then a wrapping add.
      x_3   <= x1_2 + xprod_2[47:16];
    end
    if (r4 && v3) begin
      t0_4  <= t0_prod;
      acc_4 <= crs_pkg::SUM_W'(t1_3) + crs_pkg::SUM_W'(t2_3) + t3;
      x_4   <= x_3;
    end
  end

  assign out_valid    = v4;
  assign out_data.t0  = t0_4;
  assign out_data.acc = acc_4;
  assign out_data.x   = x_4;

`ifndef SYNTHESIS
  a_mu2_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (mu2_2 <= mu_2))
    else $error("mu squared exceeds mu");

  a_mu3_bound: assert property (@(posedge clk) disable iff (rst)
    (v2 && r3) |=> (v3 && (mu3_3 <= $past(mu2_2))))
    else $error("mu cubed exceeds mu squared");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_ready) |=> (v4 && $stable(t0_4) && $stable(acc_4) && $stable(x_4)))
    else $error("last product stage changed while stalled");
`endif

endmodule

>>> hw/rtl/crs_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_sum
// Final stage: adds the cubic terms, scales y to Q27.8 and holds the result.
// ----------------------------------------------------------------------------
module crs_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  crs_pkg::pow_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [crs_pkg::X_W-1:0]     point_x,
  output logic signed [crs_pkg::Y_W-1:0]     point_y
);

  logic                              valid;
  logic                              en;
  logic signed [crs_pkg::SUM_W-1:0]  sum;
  logic [crs_pkg::X_W-1:0]           x_q;
  logic [crs_pkg::Y_W-1:0]           y_q;

  assign sum = crs_pkg::SUM_W'(in_data.t0) + in_data.acc;
  assign en  = !valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Dropping the low nine bits of the two's complement sum floors it.
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      x_q <= in_data.x;
      y_q <= sum[crs_pkg::Y_W+8:9];
    end
  end

  assign out_valid = valid;
  assign point_x   = $signed(x_q);
  assign point_y   = $signed(y_q);

endmodule

>>> hw/rtl/catmull_rom_segment_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_segment_evaluator_core
// Evaluates one point of a uniform Catmull-Rom segment per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries four control heights, the
//   segment's start and end x in Q16.16 and a step index k. The output
//   channel (out_valid/out_ready) returns point_x in Q16.16 and point_y in
//   Q27.8, one result for each input transfer, in order.
//   The item passes five register stages: one stage for the coefficients
//   and step fraction, three product stages (mu^2 with the linear terms,
//   mu^3 with the square term, then the cube term) and the final sum
//   register. Throughput is one item per cycle while out_ready is high.
//   Step indexes at or beyond STEPS are evaluated as step STEPS - 1.
//   Reset clears all stage valid bits; no result is pending afterward.
//   When the receiver holds out_ready low, the pipeline fills its empty
//   stages and then deasserts in_ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module catmull_rom_segment_evaluator_core #(
  parameter int STEPS = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [crs_pkg::HEIGHT_W-1:0]       height_before,
  input  logic [crs_pkg::HEIGHT_W-1:0]       height_start,
  input  logic [crs_pkg::HEIGHT_W-1:0]       height_end,
  input  logic [crs_pkg::HEIGHT_W-1:0]       height_after,
  input  logic signed [crs_pkg::X_W-1:0]     start_x,
  input  logic signed [crs_pkg::X_W-1:0]     end_x,
  input  logic [crs_pkg::K_W-1:0]            step_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [crs_pkg::X_W-1:0]     point_x,
  output logic signed [crs_pkg::Y_W-1:0]     point_y
);

  crs_pkg::front_t front_data;
  crs_pkg::pow_t   pow_data;
  logic            front_valid;
  logic            front_ready;
  logic            pow_valid;
  logic            pow_ready;

  crs_front #(
    .STEPS (STEPS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_before (height_before),
    .height_start  (height_start),
    .height_end    (height_end),
    .height_after  (height_after),
    .start_x       (start_x),
    .end_x         (end_x),
    .step_index    (step_index),
    .out_valid     (front_valid),
    .out_ready     (front_ready),
    .out_data      (front_data)
  );

  crs_powers u_powers (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (pow_valid),
    .out_ready (pow_ready),
    .out_data  (pow_data)
  );

  crs_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pow_valid),
    .in_ready  (pow_ready),
    .in_data   (pow_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y)
  );

endmodule
